// ----- hdl/lre_pkg.sv -----
// ----------------------------------------------------------------------------
// LED ring effect engine package
// Shared widths, effect codes, sequencer states and color tables.
// ----------------------------------------------------------------------------
package lre_pkg;

   localparam int LedCount = 12;
   localparam int IdxW     = 4;

   typedef enum logic [3:0] {
      EFF_OFF    = 4'd0,
      EFF_TEST   = 4'd1,
      EFF_ATT    = 4'd2,
      EFF_GYRO   = 4'd3,
      EFF_BLINK  = 4'd4,
      EFF_FLASH  = 4'd5,
      EFF_BREATH = 4'd6,
      EFF_RED    = 4'd7,
      EFF_COLOR  = 4'd8,
      EFF_DOUBLE = 4'd9
   } effect_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SQ_P,
      ST_SQ_R,
      ST_LOAD,
      ST_WALK,
      ST_EMIT
   } state_type;

   function automatic logic [23:0] palette_color(input logic [3:0] i);
      case (i)
         4'd1:    palette_color = {8'd32, 8'd32, 8'd32};
         4'd2:    palette_color = {8'd0, 8'd64, 8'd0};
         4'd3:    palette_color = {8'd0, 8'd0, 8'd64};
         4'd4:    palette_color = {8'd64, 8'd0, 8'd0};
         4'd5:    palette_color = {8'd0, 8'd64, 8'd64};
         4'd6:    palette_color = {8'd64, 8'd64, 8'd0};
         4'd7:    palette_color = {8'd64, 8'd0, 8'd64};
         4'd8:    palette_color = {8'd0, 8'd64, 8'd0};
         default: palette_color = 24'd0;
      endcase
   endfunction

   // Colors are packed {third, second, first}.
   function automatic logic [23:0] red_color(input logic [3:0] i);
      case (i)
         4'd0:    red_color = {8'd0, 8'd128, 8'd0};
         4'd1:    red_color = {8'd0, 8'd64, 8'd0};
         4'd2:    red_color = {8'd0, 8'd32, 8'd0};
         4'd3:    red_color = {8'd0, 8'h04, 8'd0};
         4'd4:    red_color = {8'd0, 8'd2, 8'd0};
         4'd5:    red_color = {8'd0, 8'd1, 8'd0};
         default: red_color = 24'd0;
      endcase
   endfunction

   function automatic logic [23:0] spin_color(input logic [3:0] i);
      case (i)
         4'd0:    spin_color = {8'd32, 8'd0, 8'd0};
         4'd1:    spin_color = {8'd16, 8'd0, 8'd0};
         4'd2:    spin_color = {8'd8, 8'd0, 8'd0};
         4'd3:    spin_color = {8'd4, 8'd0, 8'd0};
         4'd4:    spin_color = {8'd16, 8'd16, 8'd16};
         4'd5:    spin_color = {8'd8, 8'd8, 8'd8};
         4'd6:    spin_color = {8'd4, 8'd4, 8'd4};
         4'd7:    spin_color = {8'd0, 8'd32, 8'd0};
         4'd8:    spin_color = {8'd0, 8'd16, 8'd0};
         4'd9:    spin_color = {8'd0, 8'd8, 8'd0};
         4'd10:   spin_color = {8'd0, 8'd4, 8'd0};
         4'd11:   spin_color = {8'd0, 8'd2, 8'd0};
         default: spin_color = 24'd0;
      endcase
   endfunction

endpackage

// ----- hdl/led_ring_effect_engine_core.sv -----
// ----------------------------------------------------------------------------
// LED ring effect engine core
// Per tick request: update effect state, walk the ring once, emit 12 LEDs.
// ----------------------------------------------------------------------------
// Sequence: the request is accepted in IDLE, PREP updates the effect counters,
// attitude squares pitch then roll on one shared multiplier (SQ_P, SQ_R), LOAD
// fills the ring stores on an effect change, WALK steps the ring, EMIT offers the
// LEDs; a new request is taken only once the last LED is accepted.
// Reset: synchronous; stores, effect state and headlight clear to zero.
module led_ring_effect_engine_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [3:0] effect_request, [20:4] pitch_angle, [37:21] roll_angle,
   // [53:38] rate_x, [69:54] rate_y, [85:70] rate_z, [87:86] zero
   input  logic [87:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [3:0] led_index, [11:4] byte_first, [19:12] byte_second,
   // [27:20] byte_third, [28] headlight, [31:29] zero
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast
);

   localparam logic [3:0] LastIdx = 4'(lre_pkg::LedCount - 1);

   lre_pkg::state_type state_ff, state_in;
   logic [3:0]  idx_ff, idx_in;
   logic [23:0] frame_ff [lre_pkg::LedCount];
   logic [23:0] spa_ff [lre_pkg::LedCount];
   logic [23:0] spb_ff [lre_pkg::LedCount];
   logic [23:0] wrap_ff;
   logic [3:0]  active_ff;
   logic        rst_ff;
   logic [3:0]  pal_idx_ff, pal_cnt_ff, pal_use_ff;
   logic [4:0]  lamp_cnt_ff, blink_ff;
   logic        lamp_tog_ff, lamp_out_ff;
   logic [5:0]  br_lvl_ff;
   logic        br_up_ff;
   logic [2:0]  br_mask_ff;
   logic        blink_on_ff;
   logic [16:0] pitch_ff, roll_ff;
   logic [15:0] rx_ff, ry_ff, rz_ff;
   logic [13:0] mul_a;
   logic [27:0] mul_q;
   logic [8:0]  sq_p_ff, sq_r_ff;   // integer magnitude, at most 400
   logic        neg_p_ff, neg_r_ff;
   logic [7:0]  up_b, dn_b, rp_b, rn_b;
   logic [7:0]  gz, gy, gx;

   // Clamp a Q8.8 angle to +-20 deg and return its magnitude.
   function automatic logic [13:0] clamp_mag(input logic [16:0] v);
      logic [16:0] a;
      a = v[16] ? 17'(-v) : v;
      clamp_mag = (a > 17'd5120) ? 14'd5120 : a[13:0];
   endfunction

   function automatic logic [7:0] rate_b(input logic [15:0] v);
      logic [15:0] a;
      a = v[15] ? 16'(-v) : v;
      rate_b = (a >= 16'd510) ? 8'd255 : a[8:1];
   endfunction

   // 10 + s or 10 - s saturated to 0..255, s = +-mag.
   function automatic logic [7:0] att_b(input logic neg, input logic [8:0] mag);
      logic [9:0] t;
      if (neg) begin
         t = (mag > 9'd10) ? 10'd0 : 10'(10 - mag);
      end else begin
         t = 10'(mag) + 10'd10;
      end
      att_b = (t > 10'd255) ? 8'd255 : t[7:0];
   endfunction

   // The one shared multiplier squares pitch, then roll.
   assign mul_a = (state_ff == lre_pkg::ST_SQ_P) ? clamp_mag(pitch_ff) : clamp_mag(roll_ff);
   assign mul_q = mul_a * mul_a;

   // Pitch is negated before use.
   assign up_b = att_b(!neg_p_ff, sq_p_ff);
   assign dn_b = att_b(neg_p_ff, sq_p_ff);
   assign rp_b = att_b(neg_r_ff, sq_r_ff);
   assign rn_b = att_b(!neg_r_ff, sq_r_ff);
   assign gz = rate_b(rz_ff);
   assign gy = rate_b(ry_ff);
   assign gx = rate_b(rx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lre_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         lre_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            idx_in = 4'd0;
            if (req_tvalid) begin
               state_in = lre_pkg::ST_PREP;
            end
         end
         lre_pkg::ST_PREP: begin
            state_in = (active_ff == lre_pkg::EFF_ATT) ? lre_pkg::ST_SQ_P
                                                       : lre_pkg::ST_LOAD;
         end
         lre_pkg::ST_SQ_P: state_in = lre_pkg::ST_SQ_R;
         lre_pkg::ST_SQ_R: state_in = lre_pkg::ST_LOAD;
         lre_pkg::ST_LOAD: state_in = lre_pkg::ST_WALK;
         lre_pkg::ST_WALK: begin
            idx_in = idx_ff + 4'd1;
            if (idx_ff == LastIdx) begin
               idx_in = 4'd0;
               state_in = lre_pkg::ST_EMIT;
            end
         end
         lre_pkg::ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               idx_in = idx_ff + 4'd1;
               if (idx_ff == LastIdx) begin
                  state_in = lre_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = lre_pkg::ST_IDLE;
      endcase
   end

   // Control state: effect selection and per-effect counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 4'd0;
         active_ff <= 4'd0;
         rst_ff <= 1'b0;
         pal_idx_ff <= 4'd0;
         pal_cnt_ff <= 4'd0;
         pal_use_ff <= 4'd0;
         lamp_cnt_ff <= 5'd0;
         lamp_tog_ff <= 1'b0;
         lamp_out_ff <= 1'b0;
         blink_ff <= 5'd0;
         blink_on_ff <= 1'b0;
         br_lvl_ff <= 6'd0;
         br_up_ff <= 1'b0;
         br_mask_ff <= 3'd0;
      end else begin
         idx_ff <= idx_in;
         if (state_ff == lre_pkg::ST_IDLE && req_tvalid) begin
            if (req_tdata[3:0] <= 4'd9) begin
               active_ff <= req_tdata[3:0];
               rst_ff <= req_tdata[3:0] != active_ff;
            end else begin
               rst_ff <= 1'b0;
            end
         end
         if (state_ff == lre_pkg::ST_PREP) begin
            case (active_ff)
               lre_pkg::EFF_OFF: lamp_out_ff <= 1'b0;
               lre_pkg::EFF_FLASH: lamp_out_ff <= 1'b1;
               lre_pkg::EFF_TEST: begin
                  logic [3:0] pi, pc;
                  logic [4:0] lc;
                  logic       lt;
                  pi = rst_ff ? 4'd0 : pal_idx_ff;
                  pc = rst_ff ? 4'd0 : pal_cnt_ff;
                  lc = rst_ff ? 5'd0 : lamp_cnt_ff;
                  lt = rst_ff ? 1'b0 : lamp_tog_ff;
                  if (pi >= 4'd9) pi = 4'd0;
                  pal_use_ff <= pi;
                  pc = pc + 4'd1;
                  if (pc >= 4'd10) begin
                     pc = 4'd0;
                     pi = (pi == 4'd8) ? 4'd0 : pi + 4'd1;
                  end
                  lc = lc + 5'd1;
                  if (lc >= 5'd30) begin
                     lc = 5'd0;
                     lt = !lt;
                  end
                  pal_idx_ff <= pi;
                  pal_cnt_ff <= pc;
                  lamp_cnt_ff <= lc;
                  lamp_tog_ff <= lt;
                  lamp_out_ff <= lt;
               end
               lre_pkg::EFF_BLINK: begin
                  logic [4:0] b;
                  b = rst_ff ? 5'd0 : blink_ff;
                  blink_on_ff <= (b < 5'd10) && b[0];
                  b = b + 5'd1;
                  blink_ff <= (b >= 5'd20) ? 5'd0 : b;
               end
               lre_pkg::EFF_BREATH: begin
                  logic [5:0] l;
                  logic       u;
                  logic [2:0] m;
                  l = rst_ff ? 6'd0 : br_lvl_ff;
                  u = rst_ff ? 1'b1 : br_up_ff;
                  m = rst_ff ? 3'd1 : br_mask_ff;
                  if (u) begin
                     l = l + 6'd1;
                     if (l > 6'd30) u = 1'b0;
                  end else begin
                     if (l != 6'd0) l = l - 6'd1;
                     if (l == 6'd0) begin
                        u = 1'b1;
                        m = m + 3'd1;
                        if (m == 3'd0) m = 3'd1;
                     end
                  end
                  br_lvl_ff <= l;
                  br_up_ff <= u;
                  br_mask_ff <= m;
               end
               default: ;
            endcase
         end
      end
   end

   // Payload: sampled inputs, squares and the three ring stores.
   always_ff @(posedge clock) begin
      logic [7:0]  v;
      logic [23:0] f;
      v = 8'(10'(br_lvl_ff) * 10'd3);
      if (reset) begin
         for (int i = 0; i < lre_pkg::LedCount; i++) begin
            frame_ff[i] <= 24'd0;
            spa_ff[i] <= 24'd0;
            spb_ff[i] <= 24'd0;
         end
      end else begin
         if (state_ff == lre_pkg::ST_IDLE && req_tvalid) begin
            pitch_ff <= req_tdata[20:4];
            roll_ff <= req_tdata[37:21];
            rx_ff <= req_tdata[53:38];
            ry_ff <= req_tdata[69:54];
            rz_ff <= req_tdata[85:70];
         end
         if (state_ff == lre_pkg::ST_SQ_P) begin
            sq_p_ff <= mul_q[24:16];
            neg_p_ff <= pitch_ff[16];
         end
         if (state_ff == lre_pkg::ST_SQ_R) begin
            sq_r_ff <= mul_q[24:16];
            neg_r_ff <= roll_ff[16];
         end
         // Entry loads on an effect change: attitude clears the frame, spin effects load colors.
         if (state_ff == lre_pkg::ST_LOAD && rst_ff) begin
            for (int i = 0; i < lre_pkg::LedCount; i++) begin
               case (active_ff)
                  lre_pkg::EFF_ATT: frame_ff[i] <= 24'd0;
                  lre_pkg::EFF_RED: frame_ff[i] <= lre_pkg::red_color(4'(i));
                  lre_pkg::EFF_COLOR: frame_ff[i] <= lre_pkg::spin_color(4'(i));
                  lre_pkg::EFF_DOUBLE: begin
                     spa_ff[i] <= lre_pkg::red_color(4'(i));
                     spb_ff[i] <= lre_pkg::spin_color(
                        4'((lre_pkg::LedCount - i) % lre_pkg::LedCount));
                  end
                  default: ;
               endcase
            end
         end
         // Walk: one LED per cycle through a rotating window. The frame rotates
         // every step and is back in order after twelve. Entry 0 is kept aside
         // so that the red and color spin effects can wrap it to the end on the last step.
         if (state_ff == lre_pkg::ST_WALK) begin
            if (idx_ff == 4'd0) begin
               wrap_ff <= frame_ff[0];
            end
            f = frame_ff[0];
            case (active_ff)
               lre_pkg::EFF_OFF: f = 24'd0;
               lre_pkg::EFF_TEST: f = lre_pkg::palette_color(pal_use_ff);
               lre_pkg::EFF_ATT: begin
                  if (idx_ff >= 4'd8 && idx_ff <= 4'd10) f[7:0] = up_b;
                  if (idx_ff >= 4'd2 && idx_ff <= 4'd4) f[7:0] = dn_b;
                  if (idx_ff >= 4'd5 && idx_ff <= 4'd7) f[23:16] = rn_b;
                  if (idx_ff == 4'd11 || idx_ff <= 4'd1) f[23:16] = rp_b;
               end
               lre_pkg::EFF_GYRO: f = {gx, gy, gz};
               lre_pkg::EFF_BLINK: f = blink_on_ff ? {8'd255, 16'd0} : 24'd0;
               lre_pkg::EFF_FLASH: f = 24'hFFFFFF;
               lre_pkg::EFF_BREATH:
                  f = {br_mask_ff[2] ? v : 8'd0, br_mask_ff[1] ? v : 8'd0,
                       br_mask_ff[0] ? v : 8'd0};
               lre_pkg::EFF_RED, lre_pkg::EFF_COLOR:
                  f = (idx_ff == LastIdx) ? wrap_ff : frame_ff[1];
               lre_pkg::EFF_DOUBLE: begin
                  // a shifted down: entry i+1; b shifted up: entry i-1.
                  f = {8'((9'(spa_ff[1][23:16]) + 9'(spb_ff[11][23:16])) >> 1),
                       8'((9'(spa_ff[1][15:8]) + 9'(spb_ff[11][15:8])) >> 1),
                       8'((9'(spa_ff[1][7:0]) + 9'(spb_ff[11][7:0])) >> 1)};
               end
               default: ;
            endcase
            for (int i = 0; i < lre_pkg::LedCount - 1; i++) begin
               frame_ff[i] <= frame_ff[i + 1];
            end
            frame_ff[lre_pkg::LedCount - 1] <= f;
            if (active_ff == lre_pkg::EFF_DOUBLE) begin
               if (idx_ff == LastIdx) begin
                  // After eleven steps store b already sits one place up;
                  // store a skips two places to end one place down.
                  for (int i = 0; i < lre_pkg::LedCount; i++) begin
                     spa_ff[i] <= spa_ff[(i + 2) % lre_pkg::LedCount];
                  end
               end else begin
                  for (int i = 0; i < lre_pkg::LedCount - 1; i++) begin
                     spa_ff[i] <= spa_ff[i + 1];
                     spb_ff[i] <= spb_ff[i + 1];
                  end
                  spa_ff[lre_pkg::LedCount - 1] <= spa_ff[0];
                  spb_ff[lre_pkg::LedCount - 1] <= spb_ff[0];
               end
            end
         end
         if (state_ff == lre_pkg::ST_EMIT && rsp_tready) begin
            for (int i = 0; i < lre_pkg::LedCount - 1; i++) begin
               frame_ff[i] <= frame_ff[i + 1];
            end
            frame_ff[lre_pkg::LedCount - 1] <= frame_ff[0];
         end
      end
   end

   assign rsp_tdata = {3'd0, lamp_out_ff, frame_ff[0], idx_ff};
   assign rsp_tlast = idx_ff == LastIdx;

`ifndef SYNTHESIS
   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != lre_pkg::ST_IDLE |-> !req_tready)
      else $error("ready while busy");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> state_ff == lre_pkg::ST_IDLE)
      else $error("frame did not end on last LED");
   a_flash_lamp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && active_ff == lre_pkg::EFF_FLASH |-> rsp_tdata[28])
      else $error("flashlight without headlight");
`endif

endmodule
